// ----- design/fpsr_pkg.sv -----
// Shared constants, types and codes of the five-point stencil relaxation block.
`timescale 1ns / 1ps
package fpsr_pkg;

  localparam int unsigned MAX_GRID = 64;
  localparam int unsigned GRID_AW  = $clog2(MAX_GRID);
  localparam int unsigned ADDR_W   = 2 * GRID_AW;
  localparam int unsigned CELLS    = MAX_GRID * MAX_GRID;
  localparam int unsigned SIZE_W   = 7;
  localparam int unsigned CFG_W    = 16;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned PROD_W   = DATA_W + CFG_W + 1;
  localparam int unsigned ACC_W    = PROD_W + 3;

  localparam logic [SIZE_W-1:0] GRID_RST = SIZE_W'(64);
  localparam logic [CFG_W-1:0]  ITER_RST = 16'd1;
  localparam logic [CFG_W-1:0]  COEF_N_RST = 16'd8192;
  localparam logic [CFG_W-1:0]  COEF_W_RST = 16'd5407;
  localparam logic [CFG_W-1:0]  COEF_C_RST = 16'd4096;
  localparam logic [CFG_W-1:0]  COEF_E_RST = 16'd4096;
  localparam logic [CFG_W-1:0]  COEF_S_RST = 16'd4096;

  typedef enum logic [1:0] {
    CMD_LOAD = 2'd0,
    CMD_RUN  = 2'd1,
    CMD_READ = 2'd2,
    CMD_NOP  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    REG_GRID_SIZE  = 3'd0,
    REG_ITER_COUNT = 3'd1,
    REG_COEF_N     = 3'd2,
    REG_COEF_W     = 3'd3,
    REG_COEF_C     = 3'd4,
    REG_COEF_E     = 3'd5,
    REG_COEF_S     = 3'd6,
    REG_UNUSED     = 3'd7
  } reg_e;

  typedef enum logic [2:0] {
    TAP_N = 3'd0,
    TAP_W = 3'd1,
    TAP_C = 3'd2,
    TAP_E = 3'd3,
    TAP_S = 3'd4
  } tap_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_COPY_RD,
    ST_COPY_WR,
    ST_SW_RD,
    ST_SW_MUL,
    ST_SW_ACC,
    ST_SW_WR,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic mul_en;
    logic acc_en;
    logic first;
  } mac_ctl_t;

endpackage

// ----- design/fpsr_if.sv -----
// Valid/ready channel interfaces for the command and result streams.
`timescale 1ns / 1ps
interface fpsr_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [5:0]  row;
  logic [5:0]  col;
  logic signed [31:0] cell_value;
  modport source (output valid, cmd, row, col, cell_value, input ready);
  modport sink   (input valid, cmd, row, col, cell_value, output ready);
endinterface

interface fpsr_rsp_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] read_value;
  logic        saturated;
  modport source (output valid, read_value, saturated, input ready);
  modport sink   (input valid, read_value, saturated, output ready);
endinterface

// ----- design/five_point_stencil_relaxation.sv -----
// Top level: grid buffers, command sequencer and configuration registers.
`timescale 1ns / 1ps
// A load or a nop gives its result in the cycle after the transfer; a read first passes through
// the read state. A run copies the border and then does each sweep cell by cell through one
// shared multiplier and one read port per buffer, taking the five taps of each interior cell in
// turn; no command is taken during a run. Configuration is to be written only while idle by the
// user; the block itself does not enforce it.
module five_point_stencil_relaxation import fpsr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [CFG_W-1:0]   cfg_data_i,
  fpsr_req_if.sink           req_i,
  fpsr_rsp_if.source         rsp_o
);

  logic [DATA_W-1:0] grid_first_q  [CELLS];
  logic [DATA_W-1:0] grid_second_q [CELLS];
  logic [DATA_W-1:0] rd_first_q, rd_second_q;

  logic [SIZE_W-1:0] grid_size_q;
  logic [CFG_W-1:0]  iter_cfg_q, coef_n_q, coef_w_q, coef_c_q, coef_e_q, coef_s_q;

  state_e            state_q, state_d;
  logic              cur_q, cur_d;
  logic              sticky_q, sticky_d;
  logic [GRID_AW-1:0] idx_q, idx_d, row_q, row_d, col_q, col_d;
  logic [1:0]        side_q, side_d;
  tap_e              tap_q, tap_d;
  logic [CFG_W-1:0]  iter_q, iter_d;
  logic              inside_q, inside_d;
  logic              out_valid_q, out_valid_d;
  logic [DATA_W-1:0] out_value_q, out_value_d;

  logic [SIZE_W-1:0]  n;
  logic [GRID_AW-1:0] nm1, nm2;
  logic [CFG_W-1:0]   iter_last;
  logic               req_fire, slot_free, req_inside;
  logic [ADDR_W-1:0]  raddr, waddr;
  logic [DATA_W-1:0]  wdata, src_data;
  logic               we_first, we_second, wr_en, wr_second;
  mac_ctl_t           mac_ctl;
  logic [CFG_W-1:0]   coef;
  logic signed [DATA_W-1:0] mac_res;
  logic               mac_sat;

  always_comb begin
    if (grid_size_q < SIZE_W'(3)) begin
      n = SIZE_W'(3);
    end else if (grid_size_q > SIZE_W'(MAX_GRID)) begin
      n = SIZE_W'(MAX_GRID);
    end else begin
      n = grid_size_q;
    end
  end
  assign nm1 = GRID_AW'(n - SIZE_W'(1));
  assign nm2 = GRID_AW'(n - SIZE_W'(2));
  assign iter_last = (iter_cfg_q == '0) ? '0 : iter_cfg_q - CFG_W'(1);

  assign slot_free  = !out_valid_q || rsp_o.ready;
  assign req_i.ready = (state_q == ST_IDLE) && slot_free;
  assign req_fire   = req_i.valid && req_i.ready;
  assign req_inside = ({1'b0, req_i.row} < n) && ({1'b0, req_i.col} < n);

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.read_value = out_value_q;
  assign rsp_o.saturated  = sticky_q;

  assign src_data = cur_q ? rd_second_q : rd_first_q;

  always_comb begin
    unique case (tap_q)
      TAP_N:   coef = coef_n_q;
      TAP_W:   coef = coef_w_q;
      TAP_C:   coef = coef_c_q;
      TAP_E:   coef = coef_e_q;
      TAP_S:   coef = coef_s_q;
      default: coef = '0;
    endcase
  end

  fpsr_mac u_mac (
    .clk_i    (clk_i),
    .ctl_i    (mac_ctl),
    .data_i   (src_data),
    .coef_i   (coef),
    .result_o (mac_res),
    .sat_o    (mac_sat)
  );

  always_comb begin
    state_d     = state_q;
    cur_d       = cur_q;
    sticky_d    = sticky_q;
    idx_d       = idx_q;
    side_d      = side_q;
    row_d       = row_q;
    col_d       = col_q;
    tap_d       = tap_q;
    iter_d      = iter_q;
    inside_d    = inside_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    out_value_d = out_value_q;
    raddr       = {req_i.row, req_i.col};
    waddr       = {req_i.row, req_i.col};
    wdata       = req_i.cell_value;
    wr_en       = 1'b0;
    wr_second   = cur_q;
    mac_ctl     = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (req_fire) begin
          inside_d = req_inside;
          unique case (cmd_e'(req_i.cmd))
            CMD_LOAD: begin
              if (req_inside) begin
                sticky_d = 1'b0;
                wr_en    = 1'b1;
              end
              out_valid_d = 1'b1;
              out_value_d = '0;
            end
            CMD_RUN: begin
              idx_d   = '0;
              side_d  = '0;
              iter_d  = '0;
              state_d = ST_COPY_RD;
            end
            CMD_READ: state_d = ST_READ;
            CMD_NOP: begin
              out_valid_d = 1'b1;
              out_value_d = '0;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_READ: begin
        out_valid_d = 1'b1;
        out_value_d = inside_q ? src_data : '0;
        state_d     = ST_IDLE;
      end
      ST_COPY_RD, ST_COPY_WR: begin
        unique case (side_q)
          2'd0:    raddr = {{GRID_AW{1'b0}}, idx_q};
          2'd1:    raddr = {nm1, idx_q};
          2'd2:    raddr = {idx_q, {GRID_AW{1'b0}}};
          default: raddr = {idx_q, nm1};
        endcase
        waddr = raddr;
        if (state_q == ST_COPY_RD) begin
          state_d = ST_COPY_WR;
        end else begin
          wdata     = src_data;
          wr_en     = 1'b1;
          wr_second = !cur_q;
          side_d    = side_q + 2'd1;
          state_d   = ST_COPY_RD;
          if (side_q == 2'd3) begin
            idx_d = idx_q + GRID_AW'(1);
            if (idx_q == nm1) begin
              row_d   = GRID_AW'(1);
              col_d   = GRID_AW'(1);
              tap_d   = TAP_N;
              state_d = ST_SW_RD;
            end
          end
        end
      end
      ST_SW_RD: begin
        unique case (tap_q)
          TAP_N:   raddr = {row_q - GRID_AW'(1), col_q};
          TAP_W:   raddr = {row_q, col_q - GRID_AW'(1)};
          TAP_E:   raddr = {row_q, col_q + GRID_AW'(1)};
          TAP_S:   raddr = {row_q + GRID_AW'(1), col_q};
          default: raddr = {row_q, col_q};
        endcase
        state_d = ST_SW_MUL;
      end
      ST_SW_MUL: begin
        mac_ctl.mul_en = 1'b1;
        state_d        = ST_SW_ACC;
      end
      ST_SW_ACC: begin
        mac_ctl.acc_en = 1'b1;
        mac_ctl.first  = (tap_q == TAP_N);
        if (tap_q == TAP_S) begin
          state_d = ST_SW_WR;
        end else begin
          tap_d   = tap_e'(tap_q + 3'd1);
          state_d = ST_SW_RD;
        end
      end
      ST_SW_WR: begin
        waddr     = {row_q, col_q};
        wdata     = mac_res;
        wr_en     = 1'b1;
        wr_second = !cur_q;
        sticky_d  = sticky_q | mac_sat;
        tap_d     = TAP_N;
        state_d   = ST_SW_RD;
        if (col_q == nm2) begin
          col_d = GRID_AW'(1);
          row_d = row_q + GRID_AW'(1);
          if (row_q == nm2) begin
            row_d  = GRID_AW'(1);
            cur_d  = !cur_q;
            iter_d = iter_q + CFG_W'(1);
            if (iter_q == iter_last) begin
              state_d = ST_DONE;
            end
          end
        end else begin
          col_d = col_q + GRID_AW'(1);
        end
      end
      ST_DONE: begin
        out_valid_d = 1'b1;
        out_value_d = '0;
        state_d     = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign we_first  = wr_en && !wr_second;
  assign we_second = wr_en && wr_second;

  always_ff @(posedge clk_i) begin
    if (we_first) begin
      grid_first_q[waddr] <= wdata;
    end
    rd_first_q <= grid_first_q[raddr];
  end

  always_ff @(posedge clk_i) begin
    if (we_second) begin
      grid_second_q[waddr] <= wdata;
    end
    rd_second_q <= grid_second_q[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_size_q <= GRID_RST;
      iter_cfg_q  <= ITER_RST;
      coef_n_q    <= COEF_N_RST;
      coef_w_q    <= COEF_W_RST;
      coef_c_q    <= COEF_C_RST;
      coef_e_q    <= COEF_E_RST;
      coef_s_q    <= COEF_S_RST;
    end else if (cfg_we_i) begin
      unique case (reg_e'(cfg_index_i))
        REG_GRID_SIZE:  grid_size_q <= cfg_data_i[SIZE_W-1:0];
        REG_ITER_COUNT: iter_cfg_q  <= cfg_data_i;
        REG_COEF_N:     coef_n_q    <= cfg_data_i;
        REG_COEF_W:     coef_w_q    <= cfg_data_i;
        REG_COEF_C:     coef_c_q    <= cfg_data_i;
        REG_COEF_E:     coef_e_q    <= cfg_data_i;
        REG_COEF_S:     coef_s_q    <= cfg_data_i;
        default:        ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cur_q       <= 1'b0;
      sticky_q    <= 1'b0;
      idx_q       <= '0;
      side_q      <= '0;
      row_q       <= '0;
      col_q       <= '0;
      tap_q       <= TAP_N;
      iter_q      <= '0;
      inside_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cur_q       <= cur_d;
      sticky_q    <= sticky_d;
      idx_q       <= idx_d;
      side_q      <= side_d;
      row_q       <= row_d;
      col_q       <= col_d;
      tap_q       <= tap_d;
      iter_q      <= iter_d;
      inside_q    <= inside_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_value_q <= out_value_d;
  end

`ifndef SYNTH
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.ready |-> (state_q == ST_IDLE))
    else $error("command taken while busy");

  a_one_buffer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(we_first && we_second))
    else $error("both buffers written at once");

  a_interior: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SW_WR) |-> (row_q != '0) && (col_q != '0) && (row_q < nm1) && (col_q < nm1))
    else $error("sweep outside interior");

  a_sweep_writes_other: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SW_WR) |-> (we_second == !cur_q))
    else $error("sweep writes the source buffer");

  a_result_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE) |=> out_valid_q)
    else $error("run finished without result");
`endif

endmodule

// ----- design/fpsr_mac.sv -----
// Shared multiply-accumulate unit with Q2.14 coefficients, rounding and saturation.
`timescale 1ns / 1ps
module fpsr_mac import fpsr_pkg::*; (
  input  logic                     clk_i,
  input  mac_ctl_t                 ctl_i,
  input  logic signed [DATA_W-1:0] data_i,
  input  logic [CFG_W-1:0]         coef_i,
  output logic signed [DATA_W-1:0] result_o,
  output logic                     sat_o
);

  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [ACC_W-1:0]  rnd;
  logic signed [ACC_W-15:0] quo;
  logic                     ovf;

  always_ff @(posedge clk_i) begin
    if (ctl_i.mul_en) begin
      prod_q <= data_i * $signed({1'b0, coef_i});
    end
    if (ctl_i.acc_en) begin
      acc_q <= ctl_i.first ? ACC_W'(prod_q) : acc_q + ACC_W'(prod_q);
    end
  end

  // round half up, then floor shift by 14
  assign rnd = acc_q + ACC_W'(8192);
  assign quo = rnd[ACC_W-1:14];
  assign ovf = quo[ACC_W-15:DATA_W-1] != {(ACC_W-14-DATA_W+1){quo[DATA_W-1]}};
  assign sat_o = ovf;

  always_comb begin
    if (!ovf) begin
      result_o = quo[DATA_W-1:0];
    end else if (quo[ACC_W-15]) begin
      result_o = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      result_o = {1'b0, {(DATA_W-1){1'b1}}};
    end
  end

endmodule
